// ----- hdl/fpc_pkg.sv -----
// Shared types and codes for the frontier path connectivity block.
package fpc_pkg;

   localparam int ACTION_W    = 2;
   localparam int COL_W       = 4;
   localparam int LABEL_W     = 4;
   localparam int KEEP_W      = 16;
   localparam int OUT_LABEL_W = 5;
   localparam int RSP_MAX     = 16;

   localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LINK = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MASK = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_READ = 2'd3;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LD_CLEAR,
      OP_LD_READ_COL,
      OP_LD_READ_PARTNER,
      OP_LD_DETACH,
      OP_LD_EMPTY,
      OP_LD_READ_FIRST,
      OP_LD_SET,
      OP_LD_PAIR,
      OP_LK_READ_A,
      OP_LK_READ_B,
      OP_LK_DECIDE,
      OP_LK_WRITE,
      OP_LK_EMIT,
      OP_MK_SKIP,
      OP_MK_READ,
      OP_MK_CLEAR,
      OP_MK_RELEASE,
      OP_RD_READ_PARTNER,
      OP_RD_READ_ID,
      OP_RD_EMIT
   } dp_op_type;

   typedef struct packed {
      logic      capture;
      dp_op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic a_ok;
      logic link_ok;
      logic label_ok;
      logic ld_pair;
      logic keep_bit;
      logic col_last;
      logic step_last;
   } dp_status_type;

endpackage

// ----- hdl/fpc_datapath.sv -----
// Datapath: partner, label and path-id stores, link rules, sweep counter and result register.
module fpc_datapath #(
   parameter int COLUMNS   = 16,
   parameter int MAX_LABEL = 15
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fpc_pkg::ctl_cmd_type                 cmd,
   input  logic [fpc_pkg::COL_W-1:0]            req_col_a,
   input  logic [fpc_pkg::COL_W-1:0]            req_col_b,
   input  logic [fpc_pkg::LABEL_W-1:0]          req_label_in,
   input  logic [fpc_pkg::KEEP_W-1:0]           req_keep_mask,
   output fpc_pkg::dp_status_type               status,
   output logic                                 rsp_valid,
   output logic [fpc_pkg::OUT_LABEL_W-1:0]      rsp_col_label,
   output logic                                 rsp_path_end,
   output logic                                 rsp_would_close,
   output logic                                 rsp_last
);

   localparam int CW         = $clog2(COLUMNS);
   localparam int PW         = $clog2(COLUMNS + 1);
   localparam int LABELS     = MAX_LABEL + 1;
   localparam int LW         = $clog2(LABELS);
   localparam int EMIT       = (COLUMNS < fpc_pkg::RSP_MAX) ? COLUMNS : fpc_pkg::RSP_MAX;
   localparam int LINK_STEPS = 5;
   localparam logic [PW-1:0] EMPTY     = PW'(COLUMNS);
   localparam logic [CW-1:0] LAST_COL  = CW'(EMIT - 1);
   localparam logic [7:0]    COL_LIMIT = 8'(COLUMNS);
   localparam logic [7:0]    LABEL_TOP = 8'(MAX_LABEL);

   typedef enum logic [2:0] {
      R_PAIR,
      R_NONE,
      R_CLOSE,
      R_MOVE_BA,
      R_MOVE_AB,
      R_MERGE
   } link_rule_type;

   typedef struct packed {
      logic          we;
      logic [PW-1:0] addr;
      logic [PW-1:0] data;
   } lk_wr_type;

   // Writes of one link rule, issued one per step in the order the rules define.
   function automatic lk_wr_type link_write(input link_rule_type rule, input logic [2:0] step,
                                            input logic [PW-1:0] a, input logic [PW-1:0] b,
                                            input logic [PW-1:0] pa, input logic [PW-1:0] pb);
      lk_wr_type w;
      w.we   = 1'b0;
      w.addr = a;
      w.data = EMPTY;
      unique case (rule)
         R_PAIR: begin
            if (step == 3'd0) begin
               w = '{we: 1'b1, addr: a, data: b};
            end else if (step == 3'd1) begin
               w = '{we: 1'b1, addr: b, data: a};
            end
         end
         R_NONE: begin
            w.we = 1'b0;
         end
         R_CLOSE: begin
            if (step == 3'd0) begin
               w = '{we: 1'b1, addr: a, data: EMPTY};
            end else if (step == 3'd1) begin
               w = '{we: 1'b1, addr: b, data: EMPTY};
            end
         end
         R_MOVE_BA: begin
            if (step == 3'd0) begin
               w = '{we: 1'b1, addr: b, data: EMPTY};
            end else if (step == 3'd1) begin
               w = (pb == b) ? lk_wr_type'{we: 1'b1, addr: a, data: a}
                             : lk_wr_type'{we: 1'b1, addr: pb, data: a};
            end else if (step == 3'd2 && pb != b) begin
               w = '{we: 1'b1, addr: a, data: pb};
            end
         end
         R_MOVE_AB: begin
            if (step == 3'd0) begin
               w = '{we: 1'b1, addr: a, data: EMPTY};
            end else if (step == 3'd1) begin
               w = (pa == a) ? lk_wr_type'{we: 1'b1, addr: b, data: b}
                             : lk_wr_type'{we: 1'b1, addr: pa, data: b};
            end else if (step == 3'd2 && pa != a) begin
               w = '{we: 1'b1, addr: b, data: pa};
            end
         end
         R_MERGE: begin
            if (step == 3'd0) begin
               w = '{we: 1'b1, addr: pa, data: pb};
            end else if (step == 3'd1) begin
               w = '{we: 1'b1, addr: pb, data: pa};
            end else if (step == 3'd2) begin
               w = '{we: 1'b1, addr: a, data: EMPTY};
            end else if (step == 3'd3) begin
               w = '{we: 1'b1, addr: b, data: EMPTY};
            end else if (step == 3'd4) begin
               if (pa == a) begin
                  w = '{we: 1'b1, addr: pb, data: pb};
               end else if (pb == b) begin
                  w = '{we: 1'b1, addr: pa, data: pa};
               end
            end
         end
         default: begin
            w.we = 1'b0;
         end
      endcase
      return w;
   endfunction

   // captured request
   logic [fpc_pkg::COL_W-1:0]   a_ff;
   logic [fpc_pkg::COL_W-1:0]   b_ff;
   logic [fpc_pkg::LABEL_W-1:0] label_ff;
   logic [fpc_pkg::KEEP_W-1:0]  keep_ff;

   logic [PW-1:0]       pa_ff;
   logic [PW-1:0]       pb_ff;
   logic [PW-1:0]       f_ff;
   link_rule_type       rule_ff;
   link_rule_type       rule_in;
   logic                wc_ff;
   logic [2:0]          step_ff;
   logic [CW-1:0]       col_ff;
   logic [fpc_pkg::OUT_LABEL_W-1:0] next_label_ff;

   // partner store
   logic [PW-1:0]      part_mem [COLUMNS];
   logic [COLUMNS-1:0] part_vld_ff;
   logic [PW-1:0]      part_rd_ff;
   logic               part_rd_vld_ff;
   logic [PW-1:0]      part_q;
   logic               part_we;
   logic               part_re;
   logic               part_clr;
   logic [CW-1:0]      part_wa;
   logic [CW-1:0]      part_ra;
   logic [PW-1:0]      part_wd;

   // first column of each label
   logic [PW-1:0]     first_mem [LABELS];
   logic [LABELS-1:0] first_vld_ff;
   logic [PW-1:0]     first_rd_ff;
   logic              first_rd_vld_ff;
   logic [PW-1:0]     first_q;
   logic              first_we;
   logic              first_re;
   logic              first_clr;

   // path ids of the current read
   logic [fpc_pkg::OUT_LABEL_W-1:0] path_mem [COLUMNS];
   logic [fpc_pkg::OUT_LABEL_W-1:0] path_rd_ff;
   logic                            path_we;
   logic                            path_re;
   logic [CW-1:0]                   path_ra;

   logic [7:0]    a_w;
   logic [7:0]    b_w;
   logic [7:0]    label_w;
   logic [7:0]    col_w;
   logic [CW-1:0] a_idx;
   logic [CW-1:0] b_idx;
   logic [LW-1:0] label_idx;
   logic [PW-1:0] a_p;
   logic [PW-1:0] b_p;
   logic [PW-1:0] col_p;
   lk_wr_type     lk_wr;
   logic          p_used;
   logic          p_lower;
   logic          new_path;
   logic [fpc_pkg::OUT_LABEL_W-1:0] rd_id;
   logic          col_adv;

   logic                            emit;
   logic [fpc_pkg::OUT_LABEL_W-1:0] emit_label;
   logic                            emit_adv;
   logic                            emit_wc;
   logic                            emit_last;

   logic                            rsp_valid_ff;
   logic [fpc_pkg::OUT_LABEL_W-1:0] rsp_col_label_ff;
   logic                            rsp_path_end_ff;
   logic                            rsp_would_close_ff;
   logic                            rsp_last_ff;

   assign a_w       = {4'b0000, a_ff};
   assign b_w       = {4'b0000, b_ff};
   assign label_w   = {4'b0000, label_ff};
   assign col_w     = 8'(col_ff);
   assign a_idx     = a_w[CW-1:0];
   assign b_idx     = b_w[CW-1:0];
   assign label_idx = label_w[LW-1:0];
   assign a_p       = PW'(a_w);
   assign b_p       = PW'(b_w);
   assign col_p     = PW'(col_w);

   assign part_q  = part_rd_vld_ff ? part_rd_ff : EMPTY;
   assign first_q = first_rd_vld_ff ? first_rd_ff : EMPTY;

   assign status.a_ok      = (a_w < COL_LIMIT);
   assign status.link_ok   = (a_w < COL_LIMIT) && (b_w < COL_LIMIT);
   assign status.label_ok  = (label_ff != '0) && (label_w <= LABEL_TOP);
   assign status.ld_pair   = (f_ff < EMPTY) && (f_ff != a_p) && (part_q == f_ff);
   assign status.keep_bit  = keep_ff[col_w[3:0]];
   assign status.col_last  = (col_ff == LAST_COL);
   assign status.step_last = (step_ff == 3'(LINK_STEPS - 1));

   assign lk_wr = link_write(rule_ff, step_ff, a_p, b_p, pa_ff, pb_ff);

   // Rule order matters: an empty pair wins over equal columns, closing over moves.
   always_comb begin
      priority if (pa_ff >= EMPTY && part_q >= EMPTY) begin
         rule_in = R_PAIR;
      end else if (a_p == b_p) begin
         rule_in = R_NONE;
      end else if (part_q == a_p) begin
         rule_in = R_CLOSE;
      end else if (pa_ff >= EMPTY) begin
         rule_in = R_MOVE_BA;
      end else if (part_q >= EMPTY) begin
         rule_in = R_MOVE_AB;
      end else begin
         rule_in = R_MERGE;
      end
   end

   assign p_used   = (part_q < EMPTY);
   assign p_lower  = (8'(part_q) < col_w);
   assign new_path = p_used && !p_lower;

   always_comb begin
      priority if (!p_used) begin
         rd_id = '0;
      end else if (p_lower) begin
         rd_id = path_rd_ff;
      end else begin
         rd_id = next_label_ff + 5'd1;
      end
   end

   always_comb begin
      part_we    = 1'b0;
      part_wa    = a_idx;
      part_wd    = EMPTY;
      part_re    = 1'b0;
      part_ra    = a_idx;
      part_clr   = 1'b0;
      first_we   = 1'b0;
      first_re   = 1'b0;
      first_clr  = 1'b0;
      path_we    = 1'b0;
      path_re    = 1'b0;
      path_ra    = part_q[CW-1:0];
      col_adv    = 1'b0;
      emit       = 1'b0;
      emit_label = '0;
      emit_adv   = 1'b0;
      emit_wc    = 1'b0;
      emit_last  = 1'b0;
      unique case (cmd.op)
         fpc_pkg::OP_IDLE: begin
            emit = 1'b0;
         end
         fpc_pkg::OP_LD_CLEAR: begin
            part_clr  = (a_ff == '0);
            first_clr = (a_ff == '0);
         end
         fpc_pkg::OP_LD_READ_COL: begin
            part_re = 1'b1;
            part_ra = a_idx;
         end
         fpc_pkg::OP_LD_READ_PARTNER: begin
            part_re = (part_q < EMPTY);
            part_ra = part_q[CW-1:0];
         end
         fpc_pkg::OP_LD_DETACH: begin
            // a partner that still points back becomes dangling
            part_we = (pa_ff < EMPTY) && (pa_ff != a_p) && (part_q == a_p);
            part_wa = pa_ff[CW-1:0];
            part_wd = pa_ff;
         end
         fpc_pkg::OP_LD_EMPTY: begin
            part_we  = 1'b1;
            part_wa  = a_idx;
            part_wd  = EMPTY;
            first_re = status.label_ok;
         end
         fpc_pkg::OP_LD_READ_FIRST: begin
            part_re = (first_q < EMPTY);
            part_ra = first_q[CW-1:0];
         end
         fpc_pkg::OP_LD_SET: begin
            priority if (f_ff >= EMPTY) begin
               first_we = 1'b1;
               part_we  = 1'b1;
               part_wa  = a_idx;
               part_wd  = a_p;
            end else if (f_ff == a_p) begin
               part_we = 1'b1;
               part_wa = a_idx;
               part_wd = a_p;
            end else begin
               part_we = status.ld_pair;
               part_wa = f_ff[CW-1:0];
               part_wd = a_p;
            end
         end
         fpc_pkg::OP_LD_PAIR: begin
            part_we = 1'b1;
            part_wa = a_idx;
            part_wd = f_ff;
         end
         fpc_pkg::OP_LK_READ_A: begin
            part_re = status.link_ok;
            part_ra = a_idx;
         end
         fpc_pkg::OP_LK_READ_B: begin
            part_re = 1'b1;
            part_ra = b_idx;
         end
         fpc_pkg::OP_LK_DECIDE: begin
            emit = 1'b0;
         end
         fpc_pkg::OP_LK_WRITE: begin
            part_we = lk_wr.we;
            part_wa = lk_wr.addr[CW-1:0];
            part_wd = lk_wr.data;
         end
         fpc_pkg::OP_LK_EMIT: begin
            emit      = 1'b1;
            emit_wc   = wc_ff;
            emit_last = 1'b1;
         end
         fpc_pkg::OP_MK_SKIP: begin
            col_adv = 1'b1;
         end
         fpc_pkg::OP_MK_READ: begin
            part_re = 1'b1;
            part_ra = col_ff;
         end
         fpc_pkg::OP_MK_CLEAR: begin
            part_we = 1'b1;
            part_wa = col_ff;
            part_wd = EMPTY;
         end
         fpc_pkg::OP_MK_RELEASE: begin
            part_we = p_used && (part_q != col_p);
            part_wa = part_q[CW-1:0];
            part_wd = part_q;
            col_adv = 1'b1;
         end
         fpc_pkg::OP_RD_READ_PARTNER: begin
            part_re = 1'b1;
            part_ra = col_ff;
         end
         fpc_pkg::OP_RD_READ_ID: begin
            path_re = p_used && p_lower;
            path_ra = part_q[CW-1:0];
         end
         fpc_pkg::OP_RD_EMIT: begin
            path_we    = 1'b1;
            col_adv    = 1'b1;
            emit       = 1'b1;
            emit_label = rd_id;
            emit_adv   = p_used;
            emit_last  = status.col_last;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= emit;
         if (cmd.capture) begin
            col_ff <= '0;
         end else if (col_adv && !status.col_last) begin
            col_ff <= col_ff + 1'b1;
         end
         if (cmd.capture || cmd.op == fpc_pkg::OP_LK_DECIDE) begin
            step_ff <= '0;
         end else if (cmd.op == fpc_pkg::OP_LK_WRITE) begin
            step_ff <= step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || part_clr) begin
         part_vld_ff <= '0;
      end else if (part_we) begin
         part_vld_ff[part_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || first_clr) begin
         first_vld_ff <= '0;
      end else if (first_we) begin
         first_vld_ff[label_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (part_we) begin
         part_mem[part_wa] <= part_wd;
      end
      if (part_re) begin
         part_rd_ff     <= part_mem[part_ra];
         part_rd_vld_ff <= part_vld_ff[part_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem[label_idx] <= a_p;
      end
      if (first_re) begin
         first_rd_ff     <= first_mem[label_idx];
         first_rd_vld_ff <= first_vld_ff[label_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[col_ff] <= rd_id;
      end
      if (path_re) begin
         path_rd_ff <= path_mem[path_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         a_ff          <= req_col_a;
         b_ff          <= req_col_b;
         label_ff      <= req_label_in;
         keep_ff       <= req_keep_mask;
         wc_ff         <= 1'b0;
         next_label_ff <= '0;
      end else begin
         if (cmd.op == fpc_pkg::OP_LK_DECIDE) begin
            wc_ff <= (part_q == a_p);
         end
         if (cmd.op == fpc_pkg::OP_RD_EMIT && new_path) begin
            next_label_ff <= next_label_ff + 5'd1;
         end
      end
      if (cmd.op == fpc_pkg::OP_LD_READ_PARTNER || cmd.op == fpc_pkg::OP_LK_READ_B) begin
         pa_ff <= part_q;
      end
      if (cmd.op == fpc_pkg::OP_LK_DECIDE) begin
         pb_ff   <= part_q;
         rule_ff <= rule_in;
      end
      if (cmd.op == fpc_pkg::OP_LD_READ_FIRST) begin
         f_ff <= first_q;
      end
      if (emit) begin
         rsp_col_label_ff   <= emit_label;
         rsp_path_end_ff    <= emit_adv;
         rsp_would_close_ff <= emit_wc;
         rsp_last_ff        <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_col_label   = rsp_col_label_ff;
   assign rsp_path_end    = rsp_path_end_ff;
   assign rsp_would_close = rsp_would_close_ff;
   assign rsp_last        = rsp_last_ff;

   a_label_matches_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_path_end_ff == (rsp_col_label_ff != '0)))
      else $error("emitted label disagrees with path-end flag");

   a_close_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_would_close_ff |-> rsp_last_ff)
      else $error("loop close reported on a non-final result");

   a_partner_write_range: assert property (@(posedge clock) disable iff (reset)
      part_we |-> (part_wd <= EMPTY) && (8'(part_wa) < COL_LIMIT))
      else $error("partner store written out of range");

   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= LAST_COL)
      else $error("column sweep ran past the last emitted column");

endmodule

// ----- hdl/fpc_controller.sv -----
// Controller: sequences load, link, mask and read over the datapath's single-port stores.
module fpc_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fpc_pkg::ACTION_W-1:0]    req_action,
   input  fpc_pkg::dp_status_type          status,
   output fpc_pkg::ctl_cmd_type            cmd,
   output logic                            busy
);

   typedef enum logic [19:0] {
      ST_IDLE    = 20'h00001,
      ST_LD_CLR  = 20'h00002,
      ST_LD_RP   = 20'h00004,
      ST_LD_RPP  = 20'h00008,
      ST_LD_DET  = 20'h00010,
      ST_LD_EMP  = 20'h00020,
      ST_LD_RF   = 20'h00040,
      ST_LD_SET  = 20'h00080,
      ST_LD_PAIR = 20'h00100,
      ST_LK_RA   = 20'h00200,
      ST_LK_RB   = 20'h00400,
      ST_LK_DEC  = 20'h00800,
      ST_LK_WR   = 20'h01000,
      ST_LK_OUT  = 20'h02000,
      ST_MK_RD   = 20'h04000,
      ST_MK_CLR  = 20'h08000,
      ST_MK_REL  = 20'h10000,
      ST_RD_P    = 20'h20000,
      ST_RD_Q    = 20'h40000,
      ST_RD_W    = 20'h80000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.op      = fpc_pkg::OP_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               unique case (req_action)
                  fpc_pkg::ACT_LOAD: state_in = ST_LD_CLR;
                  fpc_pkg::ACT_LINK: state_in = ST_LK_RA;
                  fpc_pkg::ACT_MASK: state_in = ST_MK_RD;
                  fpc_pkg::ACT_READ: state_in = ST_RD_P;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_LD_CLR: begin
            cmd.op   = fpc_pkg::OP_LD_CLEAR;
            state_in = status.a_ok ? ST_LD_RP : ST_IDLE;
         end
         ST_LD_RP: begin
            cmd.op   = fpc_pkg::OP_LD_READ_COL;
            state_in = ST_LD_RPP;
         end
         ST_LD_RPP: begin
            cmd.op   = fpc_pkg::OP_LD_READ_PARTNER;
            state_in = ST_LD_DET;
         end
         ST_LD_DET: begin
            cmd.op   = fpc_pkg::OP_LD_DETACH;
            state_in = ST_LD_EMP;
         end
         ST_LD_EMP: begin
            cmd.op   = fpc_pkg::OP_LD_EMPTY;
            state_in = status.label_ok ? ST_LD_RF : ST_IDLE;
         end
         ST_LD_RF: begin
            cmd.op   = fpc_pkg::OP_LD_READ_FIRST;
            state_in = ST_LD_SET;
         end
         ST_LD_SET: begin
            cmd.op   = fpc_pkg::OP_LD_SET;
            state_in = status.ld_pair ? ST_LD_PAIR : ST_IDLE;
         end
         ST_LD_PAIR: begin
            cmd.op   = fpc_pkg::OP_LD_PAIR;
            state_in = ST_IDLE;
         end
         ST_LK_RA: begin
            cmd.op   = fpc_pkg::OP_LK_READ_A;
            state_in = status.link_ok ? ST_LK_RB : ST_LK_OUT;
         end
         ST_LK_RB: begin
            cmd.op   = fpc_pkg::OP_LK_READ_B;
            state_in = ST_LK_DEC;
         end
         ST_LK_DEC: begin
            cmd.op   = fpc_pkg::OP_LK_DECIDE;
            state_in = ST_LK_WR;
         end
         ST_LK_WR: begin
            cmd.op   = fpc_pkg::OP_LK_WRITE;
            state_in = status.step_last ? ST_LK_OUT : ST_LK_WR;
         end
         ST_LK_OUT: begin
            cmd.op   = fpc_pkg::OP_LK_EMIT;
            state_in = ST_IDLE;
         end
         ST_MK_RD: begin
            // kept columns are skipped without reading the partner store
            if (status.keep_bit) begin
               cmd.op   = fpc_pkg::OP_MK_SKIP;
               state_in = status.col_last ? ST_IDLE : ST_MK_RD;
            end else begin
               cmd.op   = fpc_pkg::OP_MK_READ;
               state_in = ST_MK_CLR;
            end
         end
         ST_MK_CLR: begin
            cmd.op   = fpc_pkg::OP_MK_CLEAR;
            state_in = ST_MK_REL;
         end
         ST_MK_REL: begin
            cmd.op   = fpc_pkg::OP_MK_RELEASE;
            state_in = status.col_last ? ST_IDLE : ST_MK_RD;
         end
         ST_RD_P: begin
            cmd.op   = fpc_pkg::OP_RD_READ_PARTNER;
            state_in = ST_RD_Q;
         end
         ST_RD_Q: begin
            cmd.op   = fpc_pkg::OP_RD_READ_ID;
            state_in = ST_RD_W;
         end
         ST_RD_W: begin
            cmd.op   = fpc_pkg::OP_RD_EMIT;
            state_in = status.col_last ? ST_IDLE : ST_RD_P;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not start a sequence");

endmodule

// ----- hdl/frontier_path_connectivity.sv -----
// Top level: frontier path-end connectivity store with load, link, mask and read.
//
// An item is taken when start is high and busy is low; busy stays high until the
// item's work is done. Each result is valid for one cycle on rsp_valid and cannot be
// held off, so the receiver must take it as it appears; rsp_last marks the final
// one. All partner links sit in one single-port partner memory, whose port sets the
// order of work: a load stops after clearing for a column at or beyond COLUMNS, or
// after emptying the column for a zero or out-of-range label, else reads the label's
// first column and pairs; a link reads both columns and writes its rule step by step
// unless a column is out of range; its result is valid in the first cycle busy is low;
// mask and read sweep min(COLUMNS,16) columns; a read gives one result per column.
// Reset needs no clearing pass: valid bits on the partner and label stores clear at once.
module frontier_path_connectivity #(
   parameter int COLUMNS   = 16,
   parameter int MAX_LABEL = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [fpc_pkg::ACTION_W-1:0]     req_action,
   input  logic [fpc_pkg::COL_W-1:0]        req_col_a,
   input  logic [fpc_pkg::COL_W-1:0]        req_col_b,
   input  logic [fpc_pkg::LABEL_W-1:0]      req_label_in,
   input  logic [fpc_pkg::KEEP_W-1:0]       req_keep_mask,
   output logic                             rsp_valid,
   output logic [fpc_pkg::OUT_LABEL_W-1:0]  rsp_col_label,
   output logic                             rsp_path_end,
   output logic                             rsp_would_close,
   output logic                             rsp_last
);

   fpc_pkg::ctl_cmd_type   cmd;
   fpc_pkg::dp_status_type status;

   fpc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   fpc_datapath #(
      .COLUMNS   (COLUMNS),
      .MAX_LABEL (MAX_LABEL)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_col_a        (req_col_a),
      .req_col_b        (req_col_b),
      .req_label_in     (req_label_in),
      .req_keep_mask    (req_keep_mask),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_col_label    (rsp_col_label),
      .rsp_path_end     (rsp_path_end),
      .rsp_would_close  (rsp_would_close),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- test/fpc_checker.sv -----
// Checker for the frontier path connectivity block: predicts every result and compares.
module fpc_checker #(
   parameter int COLUMNS   = 16,
   parameter int MAX_LABEL = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [fpc_pkg::ACTION_W-1:0]     req_action,
   input  logic [fpc_pkg::COL_W-1:0]        req_col_a,
   input  logic [fpc_pkg::COL_W-1:0]        req_col_b,
   input  logic [fpc_pkg::LABEL_W-1:0]      req_label_in,
   input  logic [fpc_pkg::KEEP_W-1:0]       req_keep_mask,
   input  logic                             rsp_valid,
   input  logic [fpc_pkg::OUT_LABEL_W-1:0]  rsp_col_label,
   input  logic                             rsp_path_end,
   input  logic                             rsp_would_close,
   input  logic                             rsp_last,
   output int                               mismatches,
   output int                               awaiting,
   output int                               reports_checked,
   output int                               loops_closed
);

   typedef logic [fpc_pkg::OUT_LABEL_W-1:0] col_ptr_type;

   typedef struct packed {
      logic [fpc_pkg::OUT_LABEL_W-1:0] label;
      logic                            advances;
      logic                            closes;
      logic                            last;
   } col_report_type;

   // One value past the last column marks an empty column or an unseen label.
   localparam col_ptr_type NO_COL    = col_ptr_type'(COLUMNS);
   localparam int          EMIT_COLS = (COLUMNS < fpc_pkg::RSP_MAX) ? COLUMNS : fpc_pkg::RSP_MAX;

   col_ptr_type                     partner   [COLUMNS];
   col_ptr_type                     first_col [MAX_LABEL+1];
   logic [fpc_pkg::OUT_LABEL_W-1:0] path_num  [COLUMNS];
   col_report_type                  awaited_reports [$];
   int                              errs = 0;
   int                              checked = 0;
   int                              closes = 0;

   function automatic void clear_store();
      for (int i = 0; i < COLUMNS; i++) partner[i] = NO_COL;
      for (int i = 0; i <= MAX_LABEL; i++) first_col[i] = NO_COL;
   endfunction

   // Empty a column; a partner that pointed back to it is left dangling.
   function automatic void detach(int c);
      int p;
      p = int'(partner[c]);
      if (p < COLUMNS && p != c && partner[p] == c) partner[p] = col_ptr_type'(p);
      partner[c] = NO_COL;
   endfunction

   function automatic void apply_load(int c, int lab);
      int f;
      if (c == 0) clear_store();
      if (c >= COLUMNS) return;
      detach(c);
      if (lab == 0 || lab > MAX_LABEL) return;
      f = int'(first_col[lab]);
      if (f >= COLUMNS) begin
         first_col[lab] = col_ptr_type'(c);
         partner[c] = col_ptr_type'(c);
      end else if (f == c) begin
         partner[c] = col_ptr_type'(c);
      end else if (partner[f] == f) begin
         partner[f] = col_ptr_type'(c);
         partner[c] = col_ptr_type'(f);
      end
   endfunction

   function automatic void move_path(int far_end, int from, int dest);
      partner[from] = NO_COL;
      if (far_end == from) begin
         partner[dest] = col_ptr_type'(dest);
      end else begin
         partner[far_end] = col_ptr_type'(dest);
         partner[dest] = col_ptr_type'(far_end);
      end
   endfunction

   // Returns whether the link closes a loop, judged before the update.
   function automatic logic apply_link(int a, int b);
      int   pa, pb;
      logic ea, eb, closing;
      if (a >= COLUMNS || b >= COLUMNS) return 1'b0;
      pa = int'(partner[a]);
      pb = int'(partner[b]);
      ea = (pa >= COLUMNS);
      eb = (pb >= COLUMNS);
      closing = (pb == a);
      if (ea && eb) begin
         partner[a] = col_ptr_type'(b);
         partner[b] = col_ptr_type'(a);
      end else if (a == b) begin
      end else if (a == pb) begin
         partner[a] = NO_COL;
         partner[b] = NO_COL;
      end else if (ea) begin
         move_path(pb, b, a);
      end else if (eb) begin
         move_path(pa, a, b);
      end else begin
         // merge: join the far ends, then a dangling side leaves the other far end dangling
         partner[pa] = col_ptr_type'(pb);
         partner[pb] = col_ptr_type'(pa);
         partner[a] = NO_COL;
         partner[b] = NO_COL;
         if (pa == a) partner[pb] = col_ptr_type'(pb);
         else if (pb == b) partner[pa] = col_ptr_type'(pa);
      end
      return closing;
   endfunction

   function automatic void apply_mask(logic [fpc_pkg::KEEP_W-1:0] keep);
      int p;
      for (int c = 0; c < COLUMNS; c++) begin
         if (c < fpc_pkg::KEEP_W && !keep[c]) begin
            p = int'(partner[c]);
            partner[c] = NO_COL;
            if (p < COLUMNS && p != c) partner[p] = col_ptr_type'(p);
         end
      end
   endfunction

   // Number paths in order of their lower column and queue one report per emitted column.
   function automatic void queue_labels();
      int                              p;
      logic [fpc_pkg::OUT_LABEL_W-1:0] next_num;
      col_report_type                  r;
      next_num = '0;
      for (int c = 0; c < COLUMNS; c++) begin
         p = int'(partner[c]);
         if (p >= COLUMNS) begin
            path_num[c] = '0;
         end else if (p < c) begin
            path_num[c] = path_num[p];
         end else begin
            next_num = next_num + 1'b1;
            path_num[c] = next_num;
         end
         if (c < EMIT_COLS) begin
            r.label    = path_num[c];
            r.advances = (p < COLUMNS);
            r.closes   = 1'b0;
            r.last     = (c + 1 == EMIT_COLS);
            awaited_reports.push_back(r);
         end
      end
   endfunction

   function automatic void compare_field(string name, logic [fpc_pkg::OUT_LABEL_W-1:0] want,
                                         logic [fpc_pkg::OUT_LABEL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errs++;
      end
   endfunction

   always @(posedge clock) begin : watch
      col_report_type want;
      col_report_type link_rep;
      if (reset) begin
         clear_store();
         for (int i = 0; i < COLUMNS; i++) path_num[i] = '0;
         awaited_reports.delete();
      end else begin
         // check the transfer on the result side before taking a new item
         if (rsp_valid === 1'b1) begin
            if (awaited_reports.size() == 0) begin
               $error("unexpected result: col_label %0d path_end %0d would_close %0d last %0d",
                      rsp_col_label, rsp_path_end, rsp_would_close, rsp_last);
               errs++;
            end else begin
               want = awaited_reports.pop_front();
               checked++;
               compare_field("col_label", want.label, rsp_col_label);
               compare_field("path_end", 5'(want.advances), 5'(rsp_path_end));
               compare_field("would_close", 5'(want.closes), 5'(rsp_would_close));
               compare_field("last", 5'(want.last), 5'(rsp_last));
            end
         end
         if (start && !busy) begin
            case (req_action)
               fpc_pkg::ACT_LOAD: apply_load(int'(req_col_a), int'(req_label_in));
               fpc_pkg::ACT_LINK: begin
                  link_rep.label    = '0;
                  link_rep.advances = 1'b0;
                  link_rep.closes   = apply_link(int'(req_col_a), int'(req_col_b));
                  link_rep.last     = 1'b1;
                  if (link_rep.closes) closes++;
                  awaited_reports.push_back(link_rep);
               end
               fpc_pkg::ACT_MASK: apply_mask(req_keep_mask);
               fpc_pkg::ACT_READ: queue_labels();
               default: ;
            endcase
         end
      end
      mismatches      <= errs;
      awaiting        <= awaited_reports.size();
      reports_checked <= checked;
      loops_closed    <= closes;
   end

endmodule

// ----- test/tb_frontier_path_connectivity.sv -----
// Testbench top: drives load, link, mask and read items and gives the verdict.
module tb_frontier_path_connectivity;

   localparam int COLUMNS     = 16;
   localparam int MAX_LABEL   = 15;
   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEM_TOTAL  = 370;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [fpc_pkg::ACTION_W-1:0]        req_action;
   logic [fpc_pkg::COL_W-1:0]           req_col_a;
   logic [fpc_pkg::COL_W-1:0]           req_col_b;
   logic [fpc_pkg::LABEL_W-1:0]         req_label_in;
   logic [fpc_pkg::KEEP_W-1:0]          req_keep_mask;
   logic                                rsp_valid;
   logic [fpc_pkg::OUT_LABEL_W-1:0]     rsp_col_label;
   logic                                rsp_path_end;
   logic                                rsp_would_close;
   logic                                rsp_last;

   int mismatches;
   int awaiting;
   int reports_checked;
   int loops_closed;
   int cycle_count = 0;
   int idle_pct = 0;
   int accepted = 0;
   int n_load = 0;
   int n_link = 0;
   int n_mask = 0;
   int n_read = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   frontier_path_connectivity #(.COLUMNS(COLUMNS), .MAX_LABEL(MAX_LABEL)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_col_a(req_col_a), .req_col_b(req_col_b),
      .req_label_in(req_label_in), .req_keep_mask(req_keep_mask),
      .rsp_valid(rsp_valid), .rsp_col_label(rsp_col_label),
      .rsp_path_end(rsp_path_end), .rsp_would_close(rsp_would_close),
      .rsp_last(rsp_last)
   );

   fpc_checker #(.COLUMNS(COLUMNS), .MAX_LABEL(MAX_LABEL)) conn_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_col_a(req_col_a), .req_col_b(req_col_b),
      .req_label_in(req_label_in), .req_keep_mask(req_keep_mask),
      .rsp_valid(rsp_valid), .rsp_col_label(rsp_col_label),
      .rsp_path_end(rsp_path_end), .rsp_would_close(rsp_would_close),
      .rsp_last(rsp_last),
      .mismatches(mismatches), .awaiting(awaiting),
      .reports_checked(reports_checked), .loops_closed(loops_closed)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // Hold start high until the block takes the transfer; idle with junk fields first.
   task automatic issue(input int act, input int ca, input int cb, input int lab,
                        input int keep);
      int gap;
      gap = 0;
      while (idle_pct != 0 && gap < 20 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start         <= 1'b0;
         req_action    <= 2'($urandom_range(3));
         req_col_a     <= 4'($urandom_range(15));
         req_col_b     <= 4'($urandom_range(15));
         req_label_in  <= 4'($urandom_range(15));
         req_keep_mask <= 16'($urandom_range(16'hFFFF));
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_action    <= 2'(act);
      req_col_a     <= 4'(ca);
      req_col_b     <= 4'(cb);
      req_label_in  <= 4'(lab);
      req_keep_mask <= 16'(keep);
      @(posedge clock);
      while (busy) @(posedge clock);
      accepted++;
      case (2'(act))
         fpc_pkg::ACT_LOAD: n_load++;
         fpc_pkg::ACT_LINK: n_link++;
         fpc_pkg::ACT_MASK: n_mask++;
         default:           n_read++;
      endcase
   endtask

   initial begin
      int hi, lab_hi, lab, n_links, a, b, frontier;
      int keep;
      reset         = 1'b1;
      start         = 1'b0;
      req_action    = fpc_pkg::ACT_LOAD;
      req_col_a     = '0;
      req_col_b     = '0;
      req_label_in  = '0;
      req_keep_mask = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: every load, link and mask rule, then reads of the result
      issue(fpc_pkg::ACT_READ, 0, 0, 0, 0);
      issue(fpc_pkg::ACT_LOAD, 0, 0, 1, 0);
      issue(fpc_pkg::ACT_LOAD, 1, 0, 2, 0);
      issue(fpc_pkg::ACT_LOAD, 2, 0, 1, 0);
      issue(fpc_pkg::ACT_LOAD, 15, 15, 15, 16'hFFFF);
      issue(fpc_pkg::ACT_LOAD, 3, 0, 2, 0);
      issue(fpc_pkg::ACT_LOAD, 4, 0, 1, 0);      // third use of a label: stays empty
      issue(fpc_pkg::ACT_LOAD, 5, 0, 0, 0);      // label zero
      issue(fpc_pkg::ACT_LOAD, 3, 0, 15, 0);     // reload detaches the old pair
      issue(fpc_pkg::ACT_LOAD, 15, 0, 15, 0);    // reload the first column of a label
      issue(fpc_pkg::ACT_READ, 0, 0, 0, 0);
      issue(fpc_pkg::ACT_LINK, 4, 5, 0, 0);      // both empty: new pair
      issue(fpc_pkg::ACT_LINK, 6, 6, 0, 0);      // same empty column: dangling
      issue(fpc_pkg::ACT_LINK, 6, 6, 0, 0);      // same column, not empty: nothing
      issue(fpc_pkg::ACT_LINK, 5, 4, 0, 0);      // closes a loop, col_a above col_b
      issue(fpc_pkg::ACT_LINK, 7, 6, 0, 0);      // extend into empty col_a
      issue(fpc_pkg::ACT_LINK, 0, 8, 0, 0);      // extend into empty col_b
      issue(fpc_pkg::ACT_LINK, 1, 3, 0, 0);      // merge of two dangling ends
      issue(fpc_pkg::ACT_LINK, 7, 2, 0, 0);      // merge with col_a dangling
      issue(fpc_pkg::ACT_LINK, 9, 10, 0, 0);
      issue(fpc_pkg::ACT_LINK, 11, 12, 0, 0);
      issue(fpc_pkg::ACT_LINK, 10, 11, 0, 0);    // merge of two pairs
      issue(fpc_pkg::ACT_LINK, 9, 15, 0, 0);     // merge with col_b dangling
      issue(fpc_pkg::ACT_READ, 0, 0, 0, 0);
      issue(fpc_pkg::ACT_MASK, 0, 0, 0, 16'hFFFF);
      issue(fpc_pkg::ACT_MASK, 0, 0, 0, 16'h7FFE);
      issue(fpc_pkg::ACT_READ, 0, 0, 0, 0);
      issue(fpc_pkg::ACT_MASK, 0, 0, 0, 16'h0000);
      issue(fpc_pkg::ACT_READ, 0, 0, 0, 0);

      // random: mostly whole frontiers (load, links, optional mask, read), some noise
      frontier = 0;
      while (accepted < ITEM_TOTAL) begin
         case ((frontier / 5) % 4)
            0:       idle_pct = 0;
            1:       idle_pct = 57;
            2:       idle_pct = 0;
            default: idle_pct = 16;
         endcase
         frontier++;
         if ($urandom_range(99) < 15) begin
            issue($urandom_range(3), $urandom_range(15), $urandom_range(15),
                  $urandom_range(15), $urandom_range(16'hFFFF));
         end else begin
            hi     = ($urandom_range(3) == 0) ? 15 : $urandom_range(1, 9);
            lab_hi = ($urandom_range(4) == 0) ? 15 : $urandom_range(1, 6);
            for (int c = 0; c <= hi; c++) begin
               if (c == 0 || $urandom_range(4) != 0) begin
                  lab = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, lab_hi);
                  issue(fpc_pkg::ACT_LOAD, c, $urandom_range(15), lab, $urandom_range(16'hFFFF));
               end
            end
            n_links = $urandom_range(4);
            for (int k = 0; k < n_links; k++) begin
               a = $urandom_range(hi);
               if ($urandom_range(5) == 0) b = $urandom_range(15);
               else b = (a < 15) ? a + $urandom_range(1) : a;
               issue(fpc_pkg::ACT_LINK, a, b, $urandom_range(15), $urandom_range(16'hFFFF));
            end
            if ($urandom_range(2) == 0) begin
               case ($urandom_range(5))
                  0:       keep = 0;
                  1:       keep = 16'hFFFF;
                  2:       keep = $urandom_range(16'hFFFF);
                  default: keep = $urandom_range(16'hFFFF) | $urandom_range(16'hFFFF);
               endcase
               issue(fpc_pkg::ACT_MASK, $urandom_range(15), $urandom_range(15),
                     $urandom_range(15), keep);
            end
            issue(fpc_pkg::ACT_READ, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                  $urandom_range(16'hFFFF));
         end
      end
      start <= 1'b0;

      // drain: wait until every awaited result has arrived and the block is idle
      while (awaiting != 0 || busy) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("items: %0d loads, %0d links, %0d masks, %0d reads", n_load, n_link, n_mask,
               n_read);
      $display("results checked: %0d, loops closed: %0d, mismatches: %0d, missing: %0d",
               reports_checked, loops_closed, mismatches, awaiting);
      if (mismatches == 0 && awaiting == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
